### rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("min stack assertion failed");

// next-cycle implication, disabled while reset is low
`define MTS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("min stack assertion failed");

`endif

### rtl/mts_pkg.sv
// -----------------------------------------------------------------------------
// mts_pkg
// Types and constants of the minimum-tracking stack
// -----------------------------------------------------------------------------
package mts_pkg;

  // fixed field widths
  localparam int ValueBits  = 32;
  localparam int OccBits    = 7;
  localparam int StackDepth = 64;

  // operation codes
  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // one request
  typedef struct packed {
    action_e                     action;
    logic signed [ValueBits-1:0] push_value;
  } mts_req_t;

  // one result
  typedef struct packed {
    logic signed [ValueBits-1:0] popped_value;
    logic signed [ValueBits-1:0] current_min;
    logic                        min_valid;
    status_e                     status;
    logic [OccBits-1:0]          occupancy;
  } mts_res_t;

  // per-cycle shift control for one chain of cells
  typedef struct packed {
    logic shift_dn;
    logic shift_up;
  } mts_shift_t;

endpackage

### rtl/mts_cell.sv
// -----------------------------------------------------------------------------
// mts_cell
// One stack entry: takes the word above on a push, the word below on a pop
// -----------------------------------------------------------------------------
module mts_cell #(
  parameter int DataW = mts_pkg::ValueBits
) (
  input  logic              clk_i,
  input  mts_pkg::mts_shift_t ctrl_i,
  input  logic [DataW-1:0]  upper_i,
  input  logic [DataW-1:0]  lower_i,
  output logic [DataW-1:0]  data_o
);
  import mts_pkg::*;

  logic [DataW-1:0] data_q, data_d;

  // shift down on push, up on pop, else hold
  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_dn) begin
      data_d = upper_i;
    end else if (ctrl_i.shift_up) begin
      data_d = lower_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### rtl/min_tracking_stack_unit.sv
// -----------------------------------------------------------------------------
// min_tracking_stack_unit
// Bounded LIFO of signed words that also reports its running minimum
// -----------------------------------------------------------------------------
//  channel   | ports                       | handshake
//  ----------+-----------------------------+-------------------------------
//  request   | start, busy, req_i          | taken when start && !busy
//  result    | valid_o, res_o              | one-cycle strobe, no back-pressure
//
// One request per cycle; its result appears on the cycle after it is taken.
// The rate is set by the two chains of cells (values and minima), each of
// which shifts by one place per cycle, so the top of each stack is cell zero.
// busy stays low. Reset clears both counts and the result strobe; the cells
// hold no reset and are only read below the counts.
// -----------------------------------------------------------------------------
module min_tracking_stack_unit #(
  parameter int StackDepth = mts_pkg::StackDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  mts_pkg::mts_req_t req_i,
  output logic              valid_o,
  output mts_pkg::mts_res_t res_o
);
  import mts_pkg::*;

  localparam int CntW = $clog2(StackDepth + 1);

  logic                 accept;
  logic [CntW-1:0]      val_cnt_q, val_cnt_d;
  logic [CntW-1:0]      min_cnt_q, min_cnt_d;
  logic                 val_push, val_pop, min_push, min_pop;
  mts_shift_t           val_ctrl, min_ctrl;
  logic [ValueBits-1:0] val_cell [StackDepth];
  logic [ValueBits-1:0] min_cell [StackDepth];
  logic [ValueBits-1:0] push_word;
  logic [CntW+OccBits-1:0] occ_wide;
  mts_res_t             res_d, res_q;
  logic                 valid_q;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign push_word = req_i.push_value;

  // operation decode against the current counts
  always_comb begin
    val_push = 1'b0;
    val_pop  = 1'b0;
    min_push = 1'b0;
    min_pop  = 1'b0;
    if (accept) begin
      if (req_i.action == ACT_PUSH) begin
        if (val_cnt_q < CntW'(StackDepth)) begin
          val_push = 1'b1;
          if (min_cnt_q == '0) begin
            min_push = 1'b1;
          end else if (min_cnt_q < CntW'(StackDepth) &&
                       $signed(push_word) <= $signed(min_cell[0])) begin
            min_push = 1'b1;
          end
        end
      end else begin
        if (val_cnt_q != '0) begin
          val_pop = 1'b1;
          if (min_cnt_q != '0 && val_cell[0] == min_cell[0]) begin
            min_pop = 1'b1;
          end
        end
      end
    end
  end

  assign val_ctrl = '{shift_dn: val_push, shift_up: val_pop};
  assign min_ctrl = '{shift_dn: min_push, shift_up: min_pop};

  // count update
  always_comb begin
    val_cnt_d = val_cnt_q;
    min_cnt_d = min_cnt_q;
    if (val_push) val_cnt_d = val_cnt_q + CntW'(1);
    if (val_pop)  val_cnt_d = val_cnt_q - CntW'(1);
    if (min_push) min_cnt_d = min_cnt_q + CntW'(1);
    if (min_pop)  min_cnt_d = min_cnt_q - CntW'(1);
  end

  // value and minimum chains
  for (genvar i = 0; i < StackDepth; i++) begin : g_cells
    logic [ValueBits-1:0] val_up, val_lo, min_up, min_lo;
    if (i == 0) begin : g_top
      assign val_up = push_word;
      assign min_up = push_word;
    end else begin : g_mid
      assign val_up = val_cell[i-1];
      assign min_up = min_cell[i-1];
    end
    if (i == StackDepth - 1) begin : g_bot
      assign val_lo = '0;
      assign min_lo = '0;
    end else begin : g_inner
      assign val_lo = val_cell[i+1];
      assign min_lo = min_cell[i+1];
    end

    mts_cell #(.DataW(ValueBits)) u_val_cell (
      .clk_i  (clk_i),
      .ctrl_i (val_ctrl),
      .upper_i(val_up),
      .lower_i(val_lo),
      .data_o (val_cell[i])
    );

    mts_cell #(.DataW(ValueBits)) u_min_cell (
      .clk_i  (clk_i),
      .ctrl_i (min_ctrl),
      .upper_i(min_up),
      .lower_i(min_lo),
      .data_o (min_cell[i])
    );
  end

  assign occ_wide = {{OccBits{1'b0}}, val_cnt_d};

  // result assembly from the state after this request
  always_comb begin
    res_d              = '0;
    res_d.status       = ST_OK;
    res_d.popped_value = val_pop ? val_cell[0] : '0;
    if (req_i.action == ACT_PUSH && !val_push) begin
      res_d.status = ST_OVERFLOW;
    end else if (req_i.action == ACT_POP && !val_pop) begin
      res_d.status = ST_UNDERFLOW;
    end
    if (min_push) begin
      res_d.current_min = push_word;
    end else if (min_pop) begin
      res_d.current_min = (min_cnt_q > CntW'(1)) ? min_cell[1] : '0;
    end else begin
      res_d.current_min = (min_cnt_q != '0) ? min_cell[0] : '0;
    end
    res_d.min_valid = (val_cnt_d != '0);
    res_d.occupancy = occ_wide[OccBits-1:0];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_cnt_q <= '0;
      min_cnt_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      val_cnt_q <= val_cnt_d;
      min_cnt_q <= min_cnt_d;
      valid_q   <= accept;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

### rtl/mts_checker.sv
// -----------------------------------------------------------------------------
// mts_checker
// Port-level checks of the minimum-tracking stack, bound to the top level
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module mts_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input mts_pkg::mts_req_t req_i,
  input logic              valid_o,
  input mts_pkg::mts_res_t res_o
);
  import mts_pkg::*;

  // every taken request gives a result on the next cycle
  `MTS_ASSERT_NXT(a_res_follows, clk_i, rst_ni, start && !busy, valid_o)
  // no result without a request
  `MTS_ASSERT_NXT(a_no_spurious, clk_i, rst_ni, !(start && !busy), !valid_o)
  // an empty stack reports a zero minimum
  `MTS_ASSERT_IMP(a_empty_min, clk_i, rst_ni, valid_o && !res_o.min_valid,
                  res_o.current_min == '0)
  // a failed request returns no popped value
  `MTS_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, valid_o && res_o.status != ST_OK,
                  res_o.popped_value == '0)
  // a failed push leaves a non-empty stack
  `MTS_ASSERT_IMP(a_ovf_full, clk_i, rst_ni, valid_o && res_o.status == ST_OVERFLOW,
                  res_o.min_valid)

endmodule

bind min_tracking_stack_unit mts_checker u_mts_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .valid_o(valid_o),
  .res_o  (res_o)
);

### sim/min_tracking_stack_unit_tb.sv
// -----------------------------------------------------------------------------
// min_tracking_stack_unit_tb
// Self-checking bench for the minimum-tracking stack: requests are streamed in
// bursts, every taken request is run through a behavioural stack model and
// each result strobe is checked field by field against the oldest prediction
// -----------------------------------------------------------------------------
module min_tracking_stack_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mts_pkg::*;

  localparam int RandomOps     = 1700;
  localparam int WatchdogLimit = 200;
  localparam int DrainCycles   = 10;
  localparam int MaxReports    = 10;

  // dut connections
  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  mts_req_t req    = '0;
  logic     valid_o;
  mts_res_t res_o;

  // request stream and predicted results
  mts_req_t pending_ops[$];
  mts_res_t predicted_res[$];

  // stack model state
  logic signed [ValueBits-1:0] value_stack[StackDepth];
  logic signed [ValueBits-1:0] min_stack[StackDepth];
  int value_depth = 0;
  int min_depth   = 0;

  // generator bookkeeping
  int gen_depth = 0;
  int mismatches = 0;
  int result_count = 0;
  int idle_cycles = 0;
  int burst_left;
  int gap_left;

  min_tracking_stack_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // applies one request to the model stacks and returns its result
  function automatic mts_res_t stack_op_predict(mts_req_t r);
    mts_res_t res;
    logic signed [ValueBits-1:0] v;
    res = '0;
    res.status = ST_OK;
    v = r.push_value;
    if (r.action == ACT_PUSH) begin
      if (value_depth >= StackDepth) begin
        res.status = ST_OVERFLOW;
      end else begin
        value_stack[value_depth] = v;
        value_depth++;
        // duplicates of the minimum go on the minimum stack too
        if (min_depth == 0 || (min_depth < StackDepth && v <= min_stack[min_depth-1])) begin
          min_stack[min_depth] = v;
          min_depth++;
        end
      end
    end else begin
      if (value_depth == 0) begin
        res.status = ST_UNDERFLOW;
      end else begin
        value_depth--;
        res.popped_value = value_stack[value_depth];
        if (min_depth > 0 && value_stack[value_depth] == min_stack[min_depth-1]) begin
          min_depth--;
        end
      end
    end
    res.current_min = (min_depth > 0) ? min_stack[min_depth-1] : '0;
    res.min_valid   = (value_depth > 0);
    res.occupancy   = OccBits'(value_depth);
    return res;
  endfunction

  // queues one request, tracking the depth it leaves behind
  task automatic queue_op(action_e op, logic signed [ValueBits-1:0] v);
    mts_req_t item;
    item.action     = op;
    item.push_value = v;
    pending_ops.push_back(item);
    if (op == ACT_PUSH && gen_depth < StackDepth) gen_depth++;
    if (op == ACT_POP && gen_depth > 0) gen_depth--;
  endtask

  // mix of corner values, a narrow band for repeated minima, and full range
  function automatic logic signed [ValueBits-1:0] pick_value();
    logic signed [ValueBits-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = '0;
          3: v = -32'sd1;
          default: v = 32'sd1;
        endcase
      end
      1, 2, 3: v = $urandom_range(0, 16) - 8;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // request driver: bursts of requests separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start      <= 1'b0;
      req        <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (start && !busy) begin
        predicted_res.push_back(stack_op_predict(req));
      end
      if (start && busy) begin
        // hold the request until it is taken
      end else if (gap_left > 0 || pending_ops.size() == 0) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        start <= 1'b1;
        req   <= pending_ops.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    mts_res_t exp_res;
    if (rst_ni && valid_o) begin
      result_count++;
      if (predicted_res.size() == 0) begin
        if (mismatches < MaxReports) begin
          $display("unexpected result %0d: popped %0d min %0d valid %0b status %0d occ %0d",
                   result_count, res_o.popped_value, res_o.current_min, res_o.min_valid,
                   res_o.status, res_o.occupancy);
        end
        mismatches++;
      end else begin
        exp_res = predicted_res.pop_front();
        if (res_o.popped_value !== exp_res.popped_value ||
            res_o.current_min  !== exp_res.current_min  ||
            res_o.min_valid    !== exp_res.min_valid    ||
            res_o.status       !== exp_res.status       ||
            res_o.occupancy    !== exp_res.occupancy) begin
          if (mismatches < MaxReports) begin
            $display("result %0d mismatch: exp popped %0d min %0d valid %0b status %0d occ %0d",
                     result_count, exp_res.popped_value, exp_res.current_min,
                     exp_res.min_valid, exp_res.status, exp_res.occupancy);
            $display("                      got popped %0d min %0d valid %0b status %0d occ %0d",
                     res_o.popped_value, res_o.current_min, res_o.min_valid,
                     res_o.status, res_o.occupancy);
          end
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with neither a request taken nor a result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || valid_o) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired with %0d requests and %0d results outstanding",
                 pending_ops.size(), predicted_res.size());
        $display("** min_tracking_stack_unit: FAILED **");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int mode;
    int run_len;
    int push_pct;

    // directed: underflow, corner values, repeated minima, drain to empty
    queue_op(ACT_POP, 32'sh7FFF_FFFF);
    queue_op(ACT_PUSH, '0);
    queue_op(ACT_PUSH, 32'sh7FFF_FFFF);
    queue_op(ACT_PUSH, 32'sh8000_0000);
    queue_op(ACT_PUSH, 32'sh8000_0000);
    queue_op(ACT_PUSH, -32'sd1);
    repeat (6) queue_op(ACT_POP, $urandom);
    queue_op(ACT_PUSH, 32'sd5);
    queue_op(ACT_PUSH, 32'sd5);
    queue_op(ACT_PUSH, 32'sd3);
    queue_op(ACT_PUSH, 32'sd3);
    queue_op(ACT_PUSH, 32'sd7);
    repeat (6) queue_op(ACT_POP, $urandom);

    // random: fills to overflow, drains to underflow and mixed runs
    mode = 0;
    while (pending_ops.size() < RandomOps + 25) begin
      case (mode)
        0: begin
          while (gen_depth < StackDepth) begin
            if ($urandom_range(0, 99) < 85) queue_op(ACT_PUSH, pick_value());
            else queue_op(ACT_POP, $urandom);
          end
          repeat ($urandom_range(1, 3)) queue_op(ACT_PUSH, pick_value());
        end
        1: begin
          while (gen_depth > 0) begin
            if ($urandom_range(0, 99) < 85) queue_op(ACT_POP, $urandom);
            else queue_op(ACT_PUSH, pick_value());
          end
          repeat ($urandom_range(1, 2)) queue_op(ACT_POP, $urandom);
        end
        default: begin
          run_len  = $urandom_range(20, 100);
          push_pct = (mode == 2) ? 60 : 40;
          repeat (run_len) begin
            if ($urandom_range(0, 99) < push_pct) queue_op(ACT_PUSH, pick_value());
            else queue_op(ACT_POP, $urandom);
          end
        end
      endcase
      mode = $urandom_range(0, 3);
    end

    // reset
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every request to be taken and answered
    @(negedge clk_i);
    while (pending_ops.size() != 0 || start || predicted_res.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);

    if (mismatches == 0 && predicted_res.size() == 0) begin
      $display("** min_tracking_stack_unit: PASSED **");
    end else begin
      $display("** min_tracking_stack_unit: FAILED **");
    end
    $finish;
  end

endmodule
